// ===== rtl/core/lhm_pkg.sv =====
// Shared types, constants and helper functions of the latency histogram monitor.
`default_nettype none
package lhm_pkg;

    localparam int NUM_BUCKETS       = 64;
    localparam int BKT_W             = 6;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int Q_DEPTH           = 4;
    localparam int SUM_W             = 64;
    localparam int DIV_W             = 72;
    localparam int PCT_W             = 7;
    localparam int PCT_DIVISOR       = 100;

    localparam logic [2:0] KIND_SAMPLE  = 3'd0;
    localparam logic [2:0] KIND_BLOCKED = 3'd1;
    localparam logic [2:0] KIND_QUEUE   = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    typedef enum logic [2:0] {
        OP_SAMPLE  = 3'd0,
        OP_BLOCKED = 3'd1,
        OP_QUEUE   = 3'd2,
        OP_QUERY   = 3'd3,
        OP_CLEAR   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] sample_ns;
        logic [31:0] q_occupancy;
        logic [31:0] capacity_now;
    } t_in;

    typedef struct packed {
        logic [63:0] avg_latency;
        logic [63:0] p50_bound;
        logic [63:0] p90_bound;
        logic [63:0] p99_bound;
        logic [31:0] sample_count;
        logic [31:0] blocked_events;
        logic [63:0] blocked_total;
        logic [31:0] peak_queue;
        logic [31:0] last_capacity;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [BKT_W-1:0]  bucket;
        logic [63:0]       ns;
        logic [31:0]       qs;
        logic [31:0]       cap;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // floor(log2(v)), 0 and 1 both land in bucket 0
    function automatic logic [BKT_W-1:0] log2_idx(input logic [63:0] v);
        logic [BKT_W-1:0] b;
        b = '0;
        for (int i = 1; i < 64; i++) begin
            if (v[i]) b = BKT_W'(i);
        end
        return b;
    endfunction

    function automatic logic [PCT_W-1:0] pct_of(input logic [1:0] idx);
        logic [PCT_W-1:0] p;
        case (idx)
            2'd0:    p = PCT_W'(50);
            2'd1:    p = PCT_W'(90);
            default: p = PCT_W'(99);
        endcase
        return p;
    endfunction

    function automatic logic [63:0] bound_of(input logic [BKT_W-1:0] b);
        return (b == '0) ? 64'd0 : (64'd1 << b);
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lhm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/lhm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module lhm_div
    import lhm_pkg::*;
#(
    parameter int DW = DIV_W,
    parameter int VW = SUM_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output t_div_stat          o_stat,
    output logic      [DW-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem, r_dvs;
    logic [VW:0]      rem_sh, rem_n;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        rem_n  = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DW-2:0], ge};
                r_rem <= rem_n[VW-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
endmodule
`default_nettype wire

// ===== rtl/core/lhm_front.sv =====
// Front end: takes input requests, drops unused kinds and works out the bucket.
`default_nettype none
module lhm_front
    import lhm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  t_in          i_item,
    output logic         o_push,
    output t_op          o_op,
    input  t_q_stat      i_qstat
);
    logic r_valid;
    t_in  r_item;
    logic legal, accept;

    always_comb begin
        unique case (r_item.kind) inside
            KIND_SAMPLE, KIND_BLOCKED, KIND_QUEUE, KIND_QUERY, KIND_CLEAR: legal = 1'b1;
            default: legal = 1'b0;
        endcase
    end

    assign o_in_stall = r_valid && i_qstat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_qstat.full && legal;

    assign o_op.kind   = t_kind'(r_item.kind);
    assign o_op.bucket = log2_idx(r_item.sample_ns);
    assign o_op.ns     = r_item.sample_ns;
    assign o_op.qs     = r_item.q_occupancy;
    assign o_op.cap    = r_item.capacity_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_qstat.full) begin
            r_valid <= 1'b0;
        end
        if (accept) r_item <= i_item;
    end
endmodule
`default_nettype wire

// ===== rtl/core/lhm_fifo.sv =====
// Short request queue between front and back.
`default_nettype none
module lhm_fifo
    import lhm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_op       i_op,
    input  wire logic i_pop,
    output t_op       o_op,
    output t_q_stat   o_stat
);
    localparam int PTR_W = $clog2(Q_DEPTH);

    t_op              r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_op         = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (PTR_W+1)'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PTR_W'(1);
            if (i_pop)  r_rp <= r_rp + PTR_W'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (PTR_W+1)'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - (PTR_W+1)'(1);
        end
        if (i_push) r_mem[r_wp] <= i_op;
    end
endmodule
`default_nettype wire

// ===== rtl/core/lhm_back.sv =====
// Back end: counters, histogram updates and the query sequence.
`default_nettype none
module lhm_back
    import lhm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_op         i_op,
    input  t_q_stat     i_qstat,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_out        o_item,
    output t_div_stat   o_div_stat
);
    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE, S_SMP_WR, S_AVG, S_WALK, S_OUT
    } t_state;

    t_state             r_state;
    logic [SUM_W-1:0]   r_lat_total, r_blk_sum;
    logic [CW-1:0]      r_lat_count, r_blk_count;
    logic [31:0]        r_peak, r_cap;
    logic [NUM_BUCKETS-1:0] r_bv;
    logic [BKT_W-1:0]   r_sb;
    logic [63:0]        r_avg;
    logic               r_zero;
    logic [DIV_W-1:0]   r_tgt [3];
    logic [BKT_W-1:0]   r_pb [3];
    logic [2:0]         r_fnd;
    logic [BKT_W:0]     r_waddr;
    logic               r_rd_ok, r_rd_v;
    logic [BKT_W-1:0]   r_rd_b;
    logic               r_cmp_ok;
    logic [BKT_W-1:0]   r_cmp_b;
    logic [63:0]        r_acc;

    logic               ram_we;
    logic [CW-1:0]      ram_wdata, ram_rdata;
    logic [BKT_W-1:0]   ram_raddr;
    logic               div_start;
    logic [DIV_W-1:0]   div_dend, div_q;
    logic [SUM_W-1:0]   div_dvs;
    logic [64:0]        sum65;
    logic [63:0]        acc_n;
    logic [63:0]        rd_c;
    logic [DIV_W-1:0]   acc_inc, acc_x100;

    lhm_ram #(.WIDTH(CW), .DEPTH(NUM_BUCKETS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sb),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lhm_div #(.DW(DIV_W), .VW(SUM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dend),
        .i_divisor  (div_dvs),
        .o_stat     (o_div_stat),
        .o_quotient (div_q)
    );

    assign o_pop     = (r_state == S_IDLE) && !i_qstat.empty;
    assign ram_we    = r_state == S_SMP_WR;
    assign ram_wdata = !r_bv[r_sb] ? CW'(1) :
                       (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CW'(1);
    assign ram_raddr = (r_state == S_WALK) ? r_waddr[BKT_W-1:0] : i_op.bucket;

    // only the average needs the divider
    assign div_start = o_pop && i_op.kind == OP_QUERY && r_lat_count != '0;
    assign div_dend  = DIV_W'(r_lat_total);
    assign div_dvs   = SUM_W'(r_lat_count);

    // saturating running sum of the histogram walk
    assign rd_c  = r_rd_v ? 64'(ram_rdata) : 64'd0;
    assign sum65 = {1'b0, r_acc} + {1'b0, rd_c};
    assign acc_n = sum65[64] ? {64{1'b1}} : sum65[63:0];

    // acc >= floor(count*P/100) exactly when 100*(acc+1) > count*P
    assign acc_inc  = DIV_W'(r_acc) + DIV_W'(1);
    assign acc_x100 = (acc_inc << 6) + (acc_inc << 5) + (acc_inc << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lat_total <= '0;
            r_lat_count <= '0;
            r_blk_count <= '0;
            r_blk_sum   <= '0;
            r_peak      <= '0;
            r_cap       <= '0;
            r_bv        <= '0;
            o_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_cmp_ok    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!o_out_valid || !i_out_stall)) o_out_valid <= 1'b1;
            else if (o_out_valid && !i_out_stall) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_op.kind)
                            OP_SAMPLE: begin
                                r_sb        <= i_op.bucket;
                                r_lat_total <= r_lat_total + i_op.ns;
                                if (r_lat_count != CNT_MAX) r_lat_count <= r_lat_count + CW'(1);
                                r_state     <= S_SMP_WR;
                            end
                            OP_BLOCKED: begin
                                r_blk_sum <= r_blk_sum + i_op.ns;
                                if (r_blk_count != CNT_MAX) r_blk_count <= r_blk_count + CW'(1);
                            end
                            OP_QUEUE: begin
                                if (i_op.qs > r_peak) r_peak <= i_op.qs;
                                r_cap <= i_op.cap;
                            end
                            OP_QUERY: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_tgt[i] <= DIV_W'((CW+PCT_W)'(r_lat_count)
                                                * (CW+PCT_W)'(pct_of(2'(i))));
                                end
                                if (r_lat_count == '0) begin
                                    r_zero  <= 1'b1;
                                    r_avg   <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_zero  <= 1'b0;
                                    r_state <= S_AVG;
                                end
                            end
                            OP_CLEAR: begin
                                r_lat_total <= '0;
                                r_lat_count <= '0;
                                r_blk_count <= '0;
                                r_blk_sum   <= '0;
                                r_peak      <= '0;
                                r_cap       <= '0;
                                r_bv        <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SMP_WR: begin
                    r_bv[r_sb] <= 1'b1;
                    r_state    <= S_IDLE;
                end
                S_AVG: begin
                    if (o_div_stat.done) begin
                        r_avg    <= div_q[63:0];
                        r_waddr  <= '0;
                        r_rd_ok  <= 1'b0;
                        r_cmp_ok <= 1'b0;
                        r_acc    <= '0;
                        r_fnd    <= '0;
                        for (int i = 0; i < 3; i++) r_pb[i] <= BKT_W'(NUM_BUCKETS - 1);
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_rd_ok  <= !r_waddr[BKT_W];
                    r_rd_b   <= r_waddr[BKT_W-1:0];
                    r_rd_v   <= r_bv[r_waddr[BKT_W-1:0]];
                    if (!r_waddr[BKT_W]) r_waddr <= r_waddr + (BKT_W+1)'(1);
                    r_cmp_ok <= r_rd_ok;
                    r_cmp_b  <= r_rd_b;
                    if (r_rd_ok) r_acc <= acc_n;
                    // compare stage runs one bucket behind the running sum
                    if (r_cmp_ok) begin
                        for (int i = 0; i < 3; i++) begin
                            if (!r_fnd[i] && r_acc != '0 && acc_x100 > r_tgt[i]) begin
                                r_fnd[i] <= 1'b1;
                                r_pb[i]  <= r_cmp_b;
                            end
                        end
                        if (r_cmp_b == BKT_W'(NUM_BUCKETS - 1)) r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_item.avg_latency    <= r_avg;
                        o_item.p50_bound      <= r_zero ? 64'd0 : bound_of(r_pb[0]);
                        o_item.p90_bound      <= r_zero ? 64'd0 : bound_of(r_pb[1]);
                        o_item.p99_bound      <= r_zero ? 64'd0 : bound_of(r_pb[2]);
                        o_item.sample_count   <= sat32(64'(r_lat_count));
                        o_item.blocked_events <= sat32(64'(r_blk_count));
                        o_item.blocked_total  <= r_blk_sum;
                        o_item.peak_queue     <= r_peak;
                        o_item.last_capacity  <= r_cap;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/latency_histogram_monitor_top.sv =====
// Top level of the latency histogram monitor.
`default_nettype none
// Latency histogram monitor. Requests carry a kind: latency sample, blocked
// interval, queue state, query or clear. The front end registers each request,
// drops unused kinds and works out the log2 bucket, then places it in a
// four-entry queue; the back end carries requests out in order. A front
// request is taken every cycle while the queue has room. In the back end a
// latency sample reads its histogram entry, then writes back the saturated
// count; blocked, queue-state and clear requests are done as they are taken.
// A query on an empty histogram goes straight to loading the result;
// otherwise the back end takes it, runs the bit-serial average division (72
// steps), walks the 64 histogram buckets in the RAM (one read a cycle; each
// read is added to the running sum, which the percentile compare then
// checks) and then loads the result. Percentile targets floor(count*P/100)
// are never divided out: a bucket qualifies once 100*(running sum + 1)
// exceeds count*P. The single result sits in an output register, so the
// back end keeps working while it waits to be taken.
// Histogram entries carry valid bits, so reset and clear take effect at once.
module latency_histogram_monitor_top
    import lhm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  t_in       i_item,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_item
);
    logic      push, pop;
    t_op       f_op, q_op;
    t_q_stat   q_stat;
    t_div_stat div_stat;

    lhm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (i_item),
        .o_push     (push),
        .o_op       (f_op),
        .i_qstat    (q_stat)
    );

    lhm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .i_pop   (pop),
        .o_op    (q_op),
        .o_stat  (q_stat)
    );

    lhm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (q_op),
        .i_qstat     (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_item      (o_item),
        .o_div_stat  (div_stat)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty)) else $error("pop from empty queue");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> $past(div_stat.busy)) else $error("divider done while idle");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_stat.full) else $error("front stalls with queue room");
`endif
endmodule
`default_nettype wire
